[hw/rtl/kec_pkg.sv]
// Shared types and constants for the key event classifier.
package kec_pkg;

  localparam int NUM_KEYS   = 2;
  localparam int LEVEL_BITS = 2;
  localparam int CNT_W      = 8;
  localparam int EV_W       = 5;
  localparam int HOLD_W     = 7;
  localparam int REP_W      = 7;
  localparam int SHORT_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [HOLD_W-1:0]  HOLD_RST  = HOLD_W'(50);
  localparam logic [REP_W-1:0]   REP_RST   = REP_W'(5);
  localparam logic [SHORT_W-1:0] SHORT_RST = SHORT_W'(20);

  localparam int EV_DOWN   = 0;
  localparam int EV_UP     = 1;
  localparam int EV_SHORT  = 2;
  localparam int EV_HOLD   = 3;
  localparam int EV_REPEAT = 4;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_PURGE = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HOLD   = 2'd0,
    CFG_REPEAT = 2'd1,
    CFG_SHORT  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [EV_W-1:0]  flags;
  } key_state_t;

endpackage

[hw/rtl/key_event_classifier.sv]
// Top level of the key event classifier: per-key counters, sticky flags and result register.
// A read item's result is registered and shown in the cycle after the item is accepted.
// One item per cycle while no result stalls; each item is done in one pass of per-key logic.
// An input item is taken whenever the result register is empty or being emptied.
// Reset (synchronous, active low) clears all counters and flags, empties the
// result register and loads the default thresholds 50, 5 and 20.
module key_event_classifier (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_op,
  input  logic [kec_pkg::LEVEL_BITS-1:0]    in_key_levels,
  input  logic                              in_key_index,
  input  logic [kec_pkg::EV_W-1:0]          in_event_mask,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [kec_pkg::EV_W-1:0]          out_events,
  input  logic                              cfg_we,
  input  logic [kec_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [kec_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  kec_pkg::key_state_t                key_r   [kec_pkg::NUM_KEYS];
  kec_pkg::key_state_t                key_nxt [kec_pkg::NUM_KEYS];
  logic [kec_pkg::HOLD_W-1:0]         hold_r;
  logic [kec_pkg::REP_W-1:0]          repeat_r;
  logic [kec_pkg::SHORT_W-1:0]        short_r;
  logic                               out_valid_r;
  logic                               out_valid_nxt;
  logic [kec_pkg::EV_W-1:0]           out_events_r;
  logic [kec_pkg::EV_W-1:0]           out_events_nxt;
  logic [kec_pkg::NUM_KEYS-1:0]       released;
  logic                               accept;

  function automatic kec_pkg::key_state_t tick_key(
    input kec_pkg::key_state_t         cur,
    input logic                        rel,
    input logic [kec_pkg::HOLD_W-1:0]  hold,
    input logic [kec_pkg::REP_W-1:0]   rep,
    input logic [kec_pkg::SHORT_W-1:0] short_lim
  );
    kec_pkg::key_state_t      res;
    logic [kec_pkg::CNT_W-1:0] hold_ext;
    logic [kec_pkg::CNT_W-1:0] limit;
    hold_ext = kec_pkg::CNT_W'(hold);
    limit    = hold_ext + kec_pkg::CNT_W'(rep);
    res      = cur;
    if (rel) begin
      if (cur.cnt > kec_pkg::CNT_W'(1)) begin
        res.flags[kec_pkg::EV_UP] = 1'b1;
        if (cur.cnt < short_lim) res.flags[kec_pkg::EV_SHORT] = 1'b1;
      end
      res.cnt = '0;
    end else begin
      if (cur.cnt == kec_pkg::CNT_W'(1)) begin
        res.flags[kec_pkg::EV_DOWN] = 1'b1;
      end else if (cur.cnt > kec_pkg::CNT_W'(1)) begin
        if (cur.cnt == hold_ext) begin
          res.flags[kec_pkg::EV_HOLD] = 1'b1;
        end else if (cur.cnt >= limit) begin
          res.flags[kec_pkg::EV_REPEAT] = 1'b1;
          res.cnt = hold_ext;
        end
      end
      res.cnt = res.cnt + kec_pkg::CNT_W'(1);
    end
    return res;
  endfunction

  assign in_ready   = !out_valid_r || out_ready;
  assign accept     = in_valid && in_ready;
  assign out_valid  = out_valid_r;
  assign out_events = out_events_r;

  always_comb begin
    released = '1;
    for (int k = 0; k < kec_pkg::LEVEL_BITS; k++) begin
      if (k < kec_pkg::NUM_KEYS) released[k] = in_key_levels[k];
    end
  end

  always_comb begin
    key_nxt        = key_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_events_nxt = out_events_r;
    if (accept) begin
      unique case (in_op)
        kec_pkg::OP_TICK: begin
          for (int k = 0; k < kec_pkg::NUM_KEYS; k++) begin
            key_nxt[k] = tick_key(key_r[k], released[k], hold_r, repeat_r, short_r);
          end
        end
        kec_pkg::OP_READ: begin
          out_valid_nxt  = 1'b1;
          out_events_nxt = '0;
          for (int k = 0; k < kec_pkg::NUM_KEYS; k++) begin
            if (k == int'(in_key_index)) begin
              out_events_nxt   = key_r[k].flags & in_event_mask;
              key_nxt[k].flags = key_r[k].flags & ~in_event_mask;
            end
          end
        end
        kec_pkg::OP_PURGE: begin
          for (int k = 0; k < kec_pkg::NUM_KEYS; k++) begin
            key_nxt[k].flags = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < kec_pkg::NUM_KEYS; k++) begin
        key_r[k] <= '0;
      end
      hold_r      <= kec_pkg::HOLD_RST;
      repeat_r    <= kec_pkg::REP_RST;
      short_r     <= kec_pkg::SHORT_RST;
      out_valid_r <= 1'b0;
    end else begin
      key_r       <= key_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          kec_pkg::CFG_HOLD:   hold_r   <= cfg_wdata[kec_pkg::HOLD_W-1:0];
          kec_pkg::CFG_REPEAT: repeat_r <= cfg_wdata[kec_pkg::REP_W-1:0];
          kec_pkg::CFG_SHORT:  short_r  <= cfg_wdata[kec_pkg::SHORT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_events_r <= out_events_nxt;
  end

endmodule

[hw/rtl/kec_checker.sv]
// Port-level assertions for the key event classifier and their bind.
module kec_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic [1:0]                     in_op,
  input logic [kec_pkg::EV_W-1:0]       in_event_mask,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [kec_pkg::EV_W-1:0]       out_events
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result pending right after reset.");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_events))
    else $error("Stalled result changed or vanished.");

  a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("Input ready does not follow result register occupancy.");

  a_read_masked: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_op == kec_pkg::OP_READ
    |=> out_valid && ((out_events & ~$past(in_event_mask)) == '0))
    else $error("Read item gave no result or events outside its mask.");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && !(in_valid && in_ready && in_op == kec_pkg::OP_READ) |=> !out_valid)
    else $error("Result appeared without a read item.");

endmodule

bind key_event_classifier kec_checker u_kec_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .in_op         (in_op),
  .in_event_mask (in_event_mask),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_events    (out_events)
);

[dv/tb_top.sv]
// Self-checking testbench for the key event classifier: directed table, then random phases.
`timescale 1ns / 100ps

module tb_top;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DIR_N = 25;
  localparam int DIR_SPLIT = 15;
  localparam int PHASES = 8;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [kec_pkg::EV_W-1:0] M_NONE   = '0;
  localparam logic [kec_pkg::EV_W-1:0] M_ALL    = '1;
  localparam logic [kec_pkg::EV_W-1:0] M_DOWN   = kec_pkg::EV_W'(1 << kec_pkg::EV_DOWN);
  localparam logic [kec_pkg::EV_W-1:0] M_UP     = kec_pkg::EV_W'(1 << kec_pkg::EV_UP);
  localparam logic [kec_pkg::EV_W-1:0] M_SHORT  = kec_pkg::EV_W'(1 << kec_pkg::EV_SHORT);
  localparam logic [kec_pkg::EV_W-1:0] M_HOLD   = kec_pkg::EV_W'(1 << kec_pkg::EV_HOLD);
  localparam logic [kec_pkg::EV_W-1:0] M_REPEAT = kec_pkg::EV_W'(1 << kec_pkg::EV_REPEAT);

  typedef struct packed {
    logic [1:0]                     op;
    logic [kec_pkg::LEVEL_BITS-1:0] levels;
    logic                           key;
    logic [kec_pkg::EV_W-1:0]       mask;
    logic                           pinned;
    logic [kec_pkg::EV_W-1:0]       pin;
  } dir_row_t;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  logic [1:0]                     in_op;
  logic [kec_pkg::LEVEL_BITS-1:0] in_key_levels;
  logic                           in_key_index;
  logic [kec_pkg::EV_W-1:0]       in_event_mask;
  logic                           out_valid;
  logic                           out_ready;
  logic [kec_pkg::EV_W-1:0]       out_events;
  logic                           cfg_we;
  logic [kec_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [kec_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                           pin_en;
  logic [kec_pkg::EV_W-1:0]       pin_events;

  logic [kec_pkg::CNT_W-1:0]   key_cnt [kec_pkg::NUM_KEYS];
  logic [kec_pkg::EV_W-1:0]    key_flags [kec_pkg::NUM_KEYS];
  logic [kec_pkg::HOLD_W-1:0]  hold_thr;
  logic [kec_pkg::REP_W-1:0]   rep_thr;
  logic [kec_pkg::SHORT_W-1:0] short_thr;
  logic [kec_pkg::EV_W-1:0]    pending_events [$];

  int mismatch_count = 0;
  int cycle_count = 0;
  bit idling_on = 0;
  int cur_hold;
  int cur_rep;
  int cur_short;
  bit key_down [kec_pkg::NUM_KEYS];
  int key_left [kec_pkg::NUM_KEYS];

  dir_row_t dir_rows [0:DIR_N-1] = '{
    '{kec_pkg::OP_READ,  2'b11, 1'b0, M_ALL,  1'b1, M_NONE},
    '{kec_pkg::OP_READ,  2'b11, 1'b1, M_ALL,  1'b1, M_NONE},
    '{kec_pkg::OP_TICK,  2'b00, 1'b0, M_NONE, 1'b0, M_NONE},
    '{kec_pkg::OP_TICK,  2'b00, 1'b1, M_ALL,  1'b0, M_NONE},
    '{kec_pkg::OP_TICK,  2'b11, 1'b0, M_NONE, 1'b0, M_NONE},
    '{kec_pkg::OP_READ,  2'b00, 1'b0, M_ALL,  1'b0, M_NONE},
    '{kec_pkg::OP_READ,  2'b11, 1'b1, M_UP,   1'b0, M_NONE},
    '{OP_UNUSED,         2'b00, 1'b1, M_ALL,  1'b0, M_NONE},
    '{kec_pkg::OP_READ,  2'b11, 1'b1, M_ALL,  1'b0, M_NONE},
    '{kec_pkg::OP_TICK,  2'b01, 1'b0, M_NONE, 1'b0, M_NONE},
    '{kec_pkg::OP_TICK,  2'b01, 1'b0, M_NONE, 1'b0, M_NONE},
    '{kec_pkg::OP_PURGE, 2'b00, 1'b1, M_ALL,  1'b0, M_NONE},
    '{kec_pkg::OP_READ,  2'b11, 1'b1, M_ALL,  1'b1, M_NONE},
    '{kec_pkg::OP_TICK,  2'b11, 1'b0, M_NONE, 1'b0, M_NONE},
    '{kec_pkg::OP_READ,  2'b00, 1'b1, M_NONE, 1'b1, M_NONE},
    '{kec_pkg::OP_READ,  2'b11, 1'b1, M_ALL,  1'b0, M_NONE},
    '{kec_pkg::OP_TICK,  2'b10, 1'b0, M_NONE, 1'b0, M_NONE},
    '{kec_pkg::OP_TICK,  2'b10, 1'b0, M_NONE, 1'b0, M_NONE},
    '{kec_pkg::OP_TICK,  2'b10, 1'b0, M_NONE, 1'b0, M_NONE},
    '{kec_pkg::OP_TICK,  2'b10, 1'b0, M_NONE, 1'b0, M_NONE},
    '{kec_pkg::OP_READ,  2'b10, 1'b0, M_DOWN | M_HOLD | M_REPEAT, 1'b0, M_NONE},
    '{kec_pkg::OP_TICK,  2'b10, 1'b0, M_NONE, 1'b0, M_NONE},
    '{kec_pkg::OP_TICK,  2'b11, 1'b0, M_NONE, 1'b0, M_NONE},
    '{kec_pkg::OP_READ,  2'b11, 1'b0, M_ALL,  1'b0, M_NONE},
    '{kec_pkg::OP_PURGE, 2'b11, 1'b1, M_ALL,  1'b0, M_NONE}
  };

  int ph_hold  [PHASES] = '{2, 127, 5, 0, 0, 10, 0, 50};
  int ph_rep   [PHASES] = '{1, 127, 3, 0, 0, 2, 0, 5};
  int ph_short [PHASES] = '{2, 254, 8, 0, 0, 254, 0, 20};
  int ph_items [PHASES] = '{100, 450, 100, 100, 100, 100, 100, 50};
  bit ph_idle  [PHASES] = '{1, 1, 0, 1, 1, 1, 0, 0};

  key_event_classifier uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_key_levels (in_key_levels),
    .in_key_index  (in_key_index),
    .in_event_mask (in_event_mask),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_events    (out_events),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void advance_keys(input logic [kec_pkg::LEVEL_BITS-1:0] lv);
    int c;
    logic [kec_pkg::EV_W-1:0] f;
    bit released;
    for (int k = 0; k < kec_pkg::NUM_KEYS; k++) begin
      c = key_cnt[k];
      f = key_flags[k];
      released = (k < kec_pkg::LEVEL_BITS) ? lv[k] : 1'b1;
      if (released) begin
        if (c > 1) begin
          f[kec_pkg::EV_UP] = 1'b1;
          if (c < short_thr) f[kec_pkg::EV_SHORT] = 1'b1;
        end
        c = 0;
      end else begin
        if (c == 1) begin
          f[kec_pkg::EV_DOWN] = 1'b1;
        end else if (c > 1) begin
          if (c == hold_thr) begin
            f[kec_pkg::EV_HOLD] = 1'b1;
          end else if (c >= int'(hold_thr) + int'(rep_thr)) begin
            f[kec_pkg::EV_REPEAT] = 1'b1;
            c = hold_thr;
          end
        end
        c = (c + 1) % 256;
      end
      key_cnt[k] = kec_pkg::CNT_W'(c);
      key_flags[k] = f;
    end
  endfunction

  function automatic logic [kec_pkg::EV_W-1:0] take_events(
    input logic key, input logic [kec_pkg::EV_W-1:0] mask);
    logic [kec_pkg::EV_W-1:0] ev;
    ev = key_flags[key] & mask;
    key_flags[key] = key_flags[key] & ~mask;
    return ev;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < kec_pkg::NUM_KEYS; k++) begin
        key_cnt[k] = '0;
        key_flags[k] = '0;
      end
      hold_thr = kec_pkg::HOLD_RST;
      rep_thr = kec_pkg::REP_RST;
      short_thr = kec_pkg::SHORT_RST;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_events.size() == 0) begin
          $error("events: result with no expectation, actual %0h", out_events);
          mismatch_count++;
        end else if (out_events !== pending_events[0]) begin
          $error("events mismatch: expected %0h, actual %0h", pending_events[0], out_events);
          mismatch_count++;
          void'(pending_events.pop_front());
        end else begin
          void'(pending_events.pop_front());
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          kec_pkg::CFG_HOLD:   hold_thr = cfg_wdata[kec_pkg::HOLD_W-1:0];
          kec_pkg::CFG_REPEAT: rep_thr = cfg_wdata[kec_pkg::REP_W-1:0];
          kec_pkg::CFG_SHORT:  short_thr = cfg_wdata[kec_pkg::SHORT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        case (in_op)
          kec_pkg::OP_TICK: advance_keys(in_key_levels);
          kec_pkg::OP_READ: begin
            if (pin_en) begin
              void'(take_events(in_key_index, in_event_mask));
              pending_events.push_back(pin_events);
            end else begin
              pending_events.push_back(take_events(in_key_index, in_event_mask));
            end
          end
          kec_pkg::OP_PURGE: begin
            for (int k = 0; k < kec_pkg::NUM_KEYS; k++) key_flags[k] = '0;
          end
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    out_ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (idling_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [kec_pkg::LEVEL_BITS-1:0] lv,
                           input logic key, input logic [kec_pkg::EV_W-1:0] mask,
                           input logic pinned, input logic [kec_pkg::EV_W-1:0] pin);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_key_levels <= lv;
    in_key_index <= key;
    in_event_mask <= mask;
    pin_en <= pinned;
    pin_events <= pin;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_events.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_thresholds(input int h, input int r, input int s);
    cfg_we <= 1'b1;
    cfg_index <= kec_pkg::CFG_HOLD;
    cfg_wdata <= kec_pkg::CFG_DATA_W'(h);
    @(posedge clk);
    cfg_index <= kec_pkg::CFG_REPEAT;
    cfg_wdata <= kec_pkg::CFG_DATA_W'(r);
    @(posedge clk);
    cfg_index <= kec_pkg::CFG_SHORT;
    cfg_wdata <= kec_pkg::CFG_DATA_W'(s);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_hold = h;
    cur_rep = r;
    cur_short = s;
  endtask

  task automatic send_random();
    int r;
    logic [kec_pkg::LEVEL_BITS-1:0] lv;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      for (int k = 0; k < kec_pkg::NUM_KEYS; k++) begin
        if (key_left[k] == 0) begin
          key_down[k] = !key_down[k];
          if (!key_down[k])
            key_left[k] = $urandom_range(1, 4);
          else if ($urandom_range(0, 1) == 0)
            key_left[k] = $urandom_range(1, cur_short + 2);
          else
            key_left[k] = $urandom_range(cur_hold - 1, cur_hold + 2 * cur_rep + 1);
        end
        key_left[k]--;
        lv[k] = !key_down[k];
      end
      if ($urandom_range(0, 9) == 0) lv = kec_pkg::LEVEL_BITS'($urandom);
      send_item(kec_pkg::OP_TICK, lv, 1'($urandom), kec_pkg::EV_W'($urandom), 1'b0, M_NONE);
    end else if (r < 95) begin
      send_item(kec_pkg::OP_READ, kec_pkg::LEVEL_BITS'($urandom), 1'($urandom),
                ($urandom_range(0, 9) < 7) ? M_ALL : kec_pkg::EV_W'($urandom), 1'b0, M_NONE);
    end else if (r < 98) begin
      send_item(kec_pkg::OP_PURGE, kec_pkg::LEVEL_BITS'($urandom), 1'($urandom),
                kec_pkg::EV_W'($urandom), 1'b0, M_NONE);
    end else begin
      send_item(OP_UNUSED, kec_pkg::LEVEL_BITS'($urandom), 1'($urandom),
                kec_pkg::EV_W'($urandom), 1'b0, M_NONE);
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_op <= kec_pkg::OP_TICK;
    in_key_levels <= '1;
    in_key_index <= 1'b0;
    in_event_mask <= '0;
    cfg_we <= 1'b0;
    cfg_index <= kec_pkg::CFG_HOLD;
    cfg_wdata <= '0;
    pin_en <= 1'b0;
    pin_events <= '0;
    cur_hold = kec_pkg::HOLD_RST;
    cur_rep = kec_pkg::REP_RST;
    cur_short = kec_pkg::SHORT_RST;
    for (int k = 0; k < kec_pkg::NUM_KEYS; k++) begin
      key_down[k] = 1'b0;
      key_left[k] = 0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idling_on = 1'b1;
    for (int i = 0; i < DIR_N; i++) begin
      if (i == DIR_SPLIT) begin
        wait_all_results();
        set_thresholds(2, 1, 254);
      end
      send_item(dir_rows[i].op, dir_rows[i].levels, dir_rows[i].key, dir_rows[i].mask,
                dir_rows[i].pinned, dir_rows[i].pin);
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_all_results();
      idling_on = ph_idle[p];
      set_thresholds((ph_hold[p] != 0) ? ph_hold[p] : $urandom_range(2, 12),
                     (ph_rep[p] != 0) ? ph_rep[p] : $urandom_range(1, 6),
                     (ph_short[p] != 0) ? ph_short[p] : $urandom_range(2, 30));
      for (int n = 0; n < ph_items[p]; n++) send_random();
    end

    wait_all_results();
    repeat (2) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
